/* hdl/csmsw_pkg.sv */
// ----------------------------------------------------------------------------
// csmsw_pkg
// Shared types and constants of the centered modulus switch unit.
// ----------------------------------------------------------------------------
package csmsw_pkg;

   // register indexes of the configuration port
   localparam int unsigned CsrIndexBits = 1;
   localparam logic [CsrIndexBits-1:0] CSR_OLD_MODULUS = 1'b0;
   localparam logic [CsrIndexBits-1:0] CSR_NEW_MODULUS = 1'b1;

   // fixed field widths of the ports
   localparam int unsigned FieldBits   = 64;
   localparam int unsigned RspDataBits = 72;

   // per item flags that ride along the pipeline
   typedef struct packed {
      logic out_of_range;   // input not below the old modulus
      logic negative;       // input stands for x minus old modulus
   } flags_type;

endpackage

/* hdl/csmsw_div_stage.sv */
// ----------------------------------------------------------------------------
// csmsw_div_stage
// One restoring remainder step for two lanes: the coefficient and the old
// modulus are both reduced by the new modulus, one dividend bit per stage.
// ----------------------------------------------------------------------------
module csmsw_div_stage #(
   parameter int unsigned WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  valid_in,
   input  logic [WORD_BITS-1:0]  modulus,
   input  logic [WORD_BITS-1:0]  rem_x_in,
   input  logic [WORD_BITS-1:0]  rem_q_in,
   input  logic [WORD_BITS-1:0]  bits_x_in,
   input  logic [WORD_BITS-1:0]  bits_q_in,
   input  csmsw_pkg::flags_type  flags_in,
   output logic                  valid_out,
   output logic [WORD_BITS-1:0]  rem_x_out,
   output logic [WORD_BITS-1:0]  rem_q_out,
   output logic [WORD_BITS-1:0]  bits_x_out,
   output logic [WORD_BITS-1:0]  bits_q_out,
   output csmsw_pkg::flags_type  flags_out
);

   logic                 valid_ff;
   logic [WORD_BITS-1:0] rem_x_ff, rem_x_in_nx;
   logic [WORD_BITS-1:0] rem_q_ff, rem_q_in_nx;
   logic [WORD_BITS-1:0] bits_x_ff, bits_q_ff;
   csmsw_pkg::flags_type flags_ff;
   logic [WORD_BITS:0]   trial_x, trial_q, ext_mod;

   // shift in next dividend bit, subtract modulus when it fits
   always_comb begin
      ext_mod = {1'b0, modulus};
      trial_x = {rem_x_in, bits_x_in[WORD_BITS-1]};
      trial_q = {rem_q_in, bits_q_in[WORD_BITS-1]};
      if (trial_x >= ext_mod) begin
         trial_x = trial_x - ext_mod;
      end
      if (trial_q >= ext_mod) begin
         trial_q = trial_q - ext_mod;
      end
      rem_x_in_nx = trial_x[WORD_BITS-1:0];
      rem_q_in_nx = trial_q[WORD_BITS-1:0];
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         rem_x_ff  <= rem_x_in_nx;
         rem_q_ff  <= rem_q_in_nx;
         bits_x_ff <= {bits_x_in[WORD_BITS-2:0], 1'b0};
         bits_q_ff <= {bits_q_in[WORD_BITS-2:0], 1'b0};
         flags_ff  <= flags_in;
      end
   end

   assign valid_out  = valid_ff;
   assign rem_x_out  = rem_x_ff;
   assign rem_q_out  = rem_q_ff;
   assign bits_x_out = bits_x_ff;
   assign bits_q_out = bits_q_ff;
   assign flags_out  = flags_ff;

endmodule

/* hdl/csmsw_fix.sv */
// ----------------------------------------------------------------------------
// csmsw_fix
// Final stage: applies the centered correction and holds the result until
// the receiver takes it.
// ----------------------------------------------------------------------------
module csmsw_fix #(
   parameter int unsigned WORD_BITS = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  valid_in,
   input  logic [WORD_BITS-1:0]  modulus,
   input  logic [WORD_BITS-1:0]  rem_x,
   input  logic [WORD_BITS-1:0]  rem_q,
   input  csmsw_pkg::flags_type  flags_in,
   output logic                  valid_out,
   output logic [WORD_BITS-1:0]  result_out,
   output logic                  out_of_range_out
);

   logic                 valid_ff;
   logic [WORD_BITS-1:0] result_ff, result_in;
   logic                 oor_ff;

   // subtract old modulus residue from negative inputs, wrapping once; zero for a zero modulus
   always_comb begin
      if (modulus == '0) begin
         result_in = '0;
      end else if (!flags_in.negative) begin
         result_in = rem_x;
      end else if (rem_x >= rem_q) begin
         result_in = rem_x - rem_q;
      end else begin
         result_in = rem_x + (modulus - rem_q);
      end
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= valid_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (enable) begin
         result_ff <= result_in;
         oor_ff    <= flags_in.out_of_range;
      end
   end

   assign valid_out        = valid_ff;
   assign result_out       = result_ff;
   assign out_of_range_out = oor_ff;

endmodule

/* hdl/centered_modulus_switch_unit.sv */
// ----------------------------------------------------------------------------
// centered_modulus_switch_unit
// Maps a coefficient under the old modulus to the new modulus, centered.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one coefficient per transaction; rsp_ returns one result per
//   transaction, in order: the residue under the new modulus and a flag for an
//   input not below the old modulus.
//   csr_ writes old_modulus (index 0) and new_modulus (index 1); write them
//   only while no transaction is in flight.
//   Throughput: one transaction per cycle, sustained while rsp_tready stays high.
//   Path: an accepted req_ is registered in the entry stage, passes the
//   remainder pipeline, one dividend bit per stage, and leaves the fix stage.
//   Reset: the pipeline empties, both moduli return to 2.
//   Stall: while rsp_tvalid is high and rsp_tready low, the whole pipeline
//   holds and req_tready drops; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module centered_modulus_switch_unit #(
   parameter int unsigned WORD_BITS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,    // coeff_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,    // coeff_out, out_of_range, zero pad
   input  logic        csr_we,
   input  logic [csmsw_pkg::CsrIndexBits-1:0] csr_index,
   input  logic [63:0] csr_wdata
);

   localparam int unsigned Stages = WORD_BITS;

   logic [WORD_BITS-1:0] old_mod_ff, new_mod_ff;
   logic                 enable;
   logic [WORD_BITS-1:0] x_in;
   csmsw_pkg::flags_type flags_in;

   logic                 valid_ff;
   logic [WORD_BITS-1:0] x_ff, q_ff;
   csmsw_pkg::flags_type flags_ff;

   logic                 st_valid [Stages+1];
   logic [WORD_BITS-1:0] st_rem_x [Stages+1];
   logic [WORD_BITS-1:0] st_rem_q [Stages+1];
   logic [WORD_BITS-1:0] st_bits_x [Stages+1];
   logic [WORD_BITS-1:0] st_bits_q [Stages+1];
   csmsw_pkg::flags_type st_flags [Stages+1];

   logic                 out_valid;
   logic [WORD_BITS-1:0] out_result;
   logic                 out_oor;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         old_mod_ff <= WORD_BITS'(2);
         new_mod_ff <= WORD_BITS'(2);
      end else if (csr_we) begin
         unique case (csr_index)
            csmsw_pkg::CSR_OLD_MODULUS: old_mod_ff <= csr_wdata[WORD_BITS-1:0];
            csmsw_pkg::CSR_NEW_MODULUS: new_mod_ff <= csr_wdata[WORD_BITS-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline advances unless a result waits
   assign enable     = !out_valid || rsp_tready;
   assign req_tready = enable;

   // entry stage: range and sign of the centered value
   always_comb begin
      x_in                  = req_tdata[WORD_BITS-1:0];
      flags_in.out_of_range = (x_in >= old_mod_ff);
      flags_in.negative     = !flags_in.out_of_range && (x_in > (old_mod_ff >> 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         x_ff     <= x_in;
         q_ff     <= old_mod_ff;
         flags_ff <= flags_in;
      end
   end

   assign st_valid[0]  = valid_ff;
   assign st_rem_x[0]  = '0;
   assign st_rem_q[0]  = '0;
   assign st_bits_x[0] = x_ff;
   assign st_bits_q[0] = q_ff;
   assign st_flags[0]  = flags_ff;

   // remainder pipeline, one bit per stage
   for (genvar i = 0; i < Stages; i++) begin : g_div
      csmsw_div_stage #(.WORD_BITS(WORD_BITS)) u_stage (
         .clock      (clock),
         .reset      (reset),
         .enable     (enable),
         .valid_in   (st_valid[i]),
         .modulus    (new_mod_ff),
         .rem_x_in   (st_rem_x[i]),
         .rem_q_in   (st_rem_q[i]),
         .bits_x_in  (st_bits_x[i]),
         .bits_q_in  (st_bits_q[i]),
         .flags_in   (st_flags[i]),
         .valid_out  (st_valid[i+1]),
         .rem_x_out  (st_rem_x[i+1]),
         .rem_q_out  (st_rem_q[i+1]),
         .bits_x_out (st_bits_x[i+1]),
         .bits_q_out (st_bits_q[i+1]),
         .flags_out  (st_flags[i+1])
      );
   end

   // centered correction and output register
   csmsw_fix #(.WORD_BITS(WORD_BITS)) u_fix (
      .clock            (clock),
      .reset            (reset),
      .enable           (enable),
      .valid_in         (st_valid[Stages]),
      .modulus          (new_mod_ff),
      .rem_x            (st_rem_x[Stages]),
      .rem_q            (st_rem_q[Stages]),
      .flags_in         (st_flags[Stages]),
      .valid_out        (out_valid),
      .result_out       (out_result),
      .out_of_range_out (out_oor)
   );

   assign rsp_tvalid = out_valid;
   assign rsp_tdata  = {7'b0, out_oor, (csmsw_pkg::FieldBits)'(out_result)};

endmodule

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Regression of the centered modulus switch unit.
// Coefficients are streamed under several old and new modulus pairs, with
// random idling on both sides. Each result is compared against a predicted
// residue and range flag, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;

   localparam int unsigned Latency    = 66;
   localparam int unsigned WatchLimit = 20000;

   typedef struct packed {
      logic [63:0] coeff;
      logic        out_of_range;
   } switched_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic [csmsw_pkg::CsrIndexBits-1:0] csr_index = csmsw_pkg::CSR_OLD_MODULUS;
   logic [63:0] csr_wdata = '0;

   logic [63:0]  old_mod = 64'd2;
   logic [63:0]  new_mod = 64'd2;
   switched_type pending_results[$];
   int  errors = 0;
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   bit  hold_off = 1'b0;
   int  quiet_cycles = 0;

   centered_modulus_switch_unit DUT (.*);

   always #1 clock = ~clock;

   // predicted result of one coefficient
   function automatic switched_type switch_coeff(logic [63:0] x);
      switched_type r;
      logic [63:0] a, d;
      r.out_of_range = (x >= old_mod);
      if (new_mod == 0) r.coeff = '0;
      else if (r.out_of_range || x <= (old_mod >> 1)) r.coeff = x % new_mod;
      else begin
         a = x % new_mod;
         d = old_mod % new_mod;
         r.coeff = (a >= d) ? a - d : a + (new_mod - d);
      end
      return r;
   endfunction

   // drive one transaction on the request side
   task automatic send_coeff(logic [63:0] x);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= x;
      do @(posedge clock); while (!req_tready);
      pending_results = {pending_results, switch_coeff(x)};
      @(negedge clock);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (Latency + 4) @(negedge clock);
   endtask

   task automatic write_moduli(logic [63:0] q, logic [63:0] n);
      drain();
      csr_we <= 1'b1; csr_index <= csmsw_pkg::CSR_OLD_MODULUS; csr_wdata <= q;
      @(negedge clock);
      csr_index <= csmsw_pkg::CSR_NEW_MODULUS; csr_wdata <= n;
      @(negedge clock);
      csr_we <= 1'b0;
      old_mod = q;
      new_mod = n;
   endtask

   // coefficient biased to edges of the centered range
   function automatic logic [63:0] pick_coeff();
      logic [63:0] h;
      h = old_mod >> 1;
      case ($urandom_range(7))
         0: return h;
         1: return h + 1;
         2: return old_mod - 1;
         3: return old_mod + $urandom_range(3);
         4: return {$urandom, $urandom};
         default: return old_mod > 1 ? {$urandom, $urandom} % old_mod : 64'd0;
      endcase
   endfunction

   function automatic logic [63:0] pick_mod();
      case ($urandom_range(5))
         0: return 64'hffff_ffff_ffff_ffff - $urandom_range(3);
         1: return $urandom_range(2, 40);
         2: return {$urandom, $urandom} >> $urandom_range(63);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   // response checker
   always @(posedge clock) begin
      switched_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $display("%0t unexpected result %h", $time, rsp_tdata);
            errors++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[63:0] !== want.coeff || rsp_tdata[64] !== want.out_of_range
                || rsp_tdata[71:65] !== '0) begin
               $display("%0t mismatch expected %h/%b actual %h/%b", $time,
                        want.coeff, want.out_of_range, rsp_tdata[63:0], rsp_tdata[64]);
               errors++;
            end
         end
      end
   end

   // receiver ready
   always @(negedge clock)
      rsp_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WatchLimit) begin
         $display("centered_modulus_switch_unit regression: fail");
         $finish;
      end
   end

   // extremes of the coefficient under the reset moduli, then degenerate and extreme moduli
   task automatic test_directed();
      logic [63:0] ext[6];
      ext = '{64'd0, 64'd1, 64'd2, 64'd3, 64'hffff_ffff_ffff_ffff, 64'h8000_0000_0000_0000};
      foreach (ext[i]) send_coeff(ext[i]);
      write_moduli(64'd0, 64'd7);
      send_coeff(64'd5); send_coeff(64'hffff_ffff_ffff_ffff);
      write_moduli(64'd1, 64'd0);
      send_coeff(64'd0); send_coeff(64'd9);
      write_moduli(64'd17, 64'd1);
      send_coeff(64'd8); send_coeff(64'd9); send_coeff(64'd16);
      write_moduli(64'd17, 64'd0);
      send_coeff(64'd9); send_coeff(64'd20);
      write_moduli(64'hffff_ffff_ffff_ffff, 64'hffff_ffff_ffff_fffe);
      send_coeff(64'h7fff_ffff_ffff_ffff); send_coeff(64'h8000_0000_0000_0000);
      send_coeff(64'hffff_ffff_ffff_fffe); send_coeff(64'hffff_ffff_ffff_ffff);
      write_moduli(64'd101, 64'hffff_ffff_ffff_ffff);
      send_coeff(64'd51); send_coeff(64'd100);
   endtask

   // random coefficients over random modulus pairs, idling per phase
   task automatic test_random(int idle, int stall, int items);
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      for (int i = 0; i < items; i++) begin
         if (i % 40 == 0) write_moduli(pick_mod(), pick_mod());
         send_coeff(pick_coeff());
      end
   endtask

   // receiver holds off long enough for the pipeline to fill
   task automatic test_backpressure();
      send_idle_pct = 0;
      recv_stall_pct = 0;
      drain();
      hold_off = 1'b1;
      fork
         begin repeat (300) @(negedge clock); hold_off = 1'b0; end
         for (int i = 0; i < 100; i++) send_coeff(pick_coeff());
      join
      drain();
   endtask

   initial begin
      repeat (4) @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(0, 0, 220);
      test_random(47, 0, 200);
      test_random(0, 47, 200);
      test_random(21, 21, 200);
      test_backpressure();
      drain();
      if (errors == 0 && pending_results.size() == 0)
         $display("centered_modulus_switch_unit regression: pass");
      else
         $display("centered_modulus_switch_unit regression: fail");
      $finish;
   end
endmodule

/* sim.f */
hdl/csmsw_pkg.sv
hdl/csmsw_div_stage.sv
hdl/csmsw_fix.sv
hdl/centered_modulus_switch_unit.sv
bench/tb.sv
